// ===== src/ham_planar_pixel_decoder_defines.svh =====
// assertion macros shared by the pixel decoder rtl
// no dependencies; included by the files that carry assertions
`ifndef HAM_PLANAR_PIXEL_DECODER_DEFINES_SVH
`define HAM_PLANAR_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define HPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define HPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hpd_pkg.sv =====
// types, constants and register codes for the planar pixel decoder
// no dependencies; imported by every module of the block
`default_nettype none

package hpd_pkg;

   localparam int NumPlanes     = 8;
   localparam int PixelsPerItem = 8;
   localparam int PaletteRegs   = 4;
   localparam int PaletteWords  = 16;

   localparam logic [11:0] KeepRgMask = 12'hFF0;
   localparam logic [11:0] KeepGbMask = 12'h0FF;
   localparam logic [11:0] KeepRbMask = 12'hF0F;

   localparam logic [3:0] DepthReset = 4'd6;

   // control nibble actions
   localparam logic [3:0] CtrlLoad  = 4'd0;
   localparam logic [3:0] CtrlBlue  = 4'd1;
   localparam logic [3:0] CtrlRed   = 4'd2;

   typedef enum logic [2:0] {
      RegPlaneDepth = 3'd0,
      RegPalette0   = 3'd1,
      RegPalette1   = 3'd2,
      RegPalette2   = 3'd3,
      RegPalette3   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [3:0]        plane_depth;
      logic [3:0][47:0]  palette;
   } cfg_type;

   typedef logic [NumPlanes-1:0][7:0] planes_type;

endpackage

`default_nettype wire

// ===== src/hpd_csr.sv =====
// configuration registers of the planar pixel decoder: depth and palette
// depends on hpd_pkg
`default_nettype none

module hpd_csr
   import hpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [3:0]       depth_ff, depth_in;
   logic [3:0][47:0] palette_ff, palette_in;
   logic             wr_en;
   csr_index_type    idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_index_type'(csr_paddr[5:3]);

   always_comb begin
      depth_in   = depth_ff;
      palette_in = palette_ff;
      if (wr_en) begin
         unique case (idx)
            RegPlaneDepth: depth_in      = csr_pwdata[3:0];
            RegPalette0:   palette_in[0] = csr_pwdata[47:0];
            RegPalette1:   palette_in[1] = csr_pwdata[47:0];
            RegPalette2:   palette_in[2] = csr_pwdata[47:0];
            RegPalette3:   palette_in[3] = csr_pwdata[47:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= DepthReset;
         palette_ff <= '0;
      end else begin
         depth_ff   <= depth_in;
         palette_ff <= palette_in;
      end
   end

   always_comb begin
      unique case (idx)
         RegPlaneDepth: csr_prdata = {60'd0, depth_ff};
         RegPalette0:   csr_prdata = {16'd0, palette_ff[0]};
         RegPalette1:   csr_prdata = {16'd0, palette_ff[1]};
         RegPalette2:   csr_prdata = {16'd0, palette_ff[2]};
         RegPalette3:   csr_prdata = {16'd0, palette_ff[3]};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.plane_depth = depth_ff;
   assign cfg.palette     = palette_ff;

endmodule

`default_nettype wire

// ===== src/hpd_decode.sv =====
// one-pixel hold-and-modify decode: code gather, palette/modify, descriptor
// depends on hpd_pkg
`default_nettype none

module hpd_decode
   import hpd_pkg::*;
(
   input  wire planes_type  planes,
   input  wire logic [2:0]  pix_idx,
   input  wire logic [11:0] base_color,
   input  wire cfg_type     cfg,
   output logic [11:0]      rgb,
   output logic [31:0]      descriptor
);

   logic [2:0]  bitpos;
   logic [7:0]  code;
   logic [3:0]  data;
   logic [3:0]  ctrl;
   logic [11:0] pal_color;
   logic [15:0] hi_word;
   logic [PaletteWords-1:0][11:0] pal_words;

   // leftmost pixel sits in bit 7
   assign bitpos = ~pix_idx;

   always_comb begin
      for (int p = 0; p < NumPlanes; p++) begin
         code[p] = planes[p][bitpos];
      end
   end

   assign data = code[3:0];
   assign ctrl = code[7:4];

   always_comb begin
      for (int r = 0; r < PaletteRegs; r++) begin
         for (int e = 0; e < 4; e++) begin
            pal_words[r*4+e] = cfg.palette[r][e*12 +: 12];
         end
      end
   end

   assign pal_color = pal_words[data];

   always_comb begin
      unique case (ctrl)
         CtrlLoad: rgb = pal_color;
         CtrlBlue: rgb = (base_color & KeepRgMask) | {8'd0, data};
         CtrlRed:  rgb = (base_color & KeepGbMask) | {data, 8'd0};
         default:  rgb = (base_color & KeepRbMask) | {4'd0, data, 4'd0};
      endcase
   end

   // red bit i to 4i+3, blue bit i to 4i and 4i+1
   always_comb begin
      hi_word = '0;
      for (int i = 0; i < 4; i++) begin
         hi_word[4*i+3]     = rgb[8+i];
         hi_word[4*i+1]     = rgb[i];
         hi_word[4*i]       = rgb[i];
      end
   end

   assign descriptor = {hi_word, 10'd0, rgb[7:4], 2'd0};

endmodule

`default_nettype wire

// ===== src/ham_planar_pixel_decoder.sv =====
// Hold-and-modify planar pixel decoder. Each request carries one byte of
// each of eight bitplanes and yields eight pixel results, leftmost first,
// one per cycle on the rsp channel unless rsp_ready stalls; last_of_group
// marks the eighth. A request holds the block until its eighth pixel issues,
// set by the single result register and the held color that each pixel
// feeds to the next. The request register frees as the eighth pixel enters
// the result register, so with rsp_ready held high a new request is taken
// as that pixel issues, with no gap in the output stream. Configuration
// (plane depth and the 16-color palette) sits on a 64-bit APB port, registers at 8*i.
// top level; depends on hpd_pkg, hpd_csr, hpd_decode and the defines header
`default_nettype none

`include "ham_planar_pixel_decoder_defines.svh"

module ham_planar_pixel_decoder
   import hpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_plane0_byte,
   input  wire logic [7:0]  req_plane1_byte,
   input  wire logic [7:0]  req_plane2_byte,
   input  wire logic [7:0]  req_plane3_byte,
   input  wire logic [7:0]  req_plane4_byte,
   input  wire logic [7:0]  req_plane5_byte,
   input  wire logic [7:0]  req_plane6_byte,
   input  wire logic [7:0]  req_plane7_byte,
   input  wire logic        req_row_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_pixel_rgb,
   output logic [31:0]      rsp_texel_descriptor,
   output logic             rsp_last_of_group,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type     cfg;
   planes_type  req_planes;
   planes_type  planes_ff, planes_in;
   logic        row_start_ff, row_start_in;
   logic        item_valid_ff, item_valid_in;
   logic [2:0]  pix_cnt_ff, pix_cnt_in;
   logic [11:0] held_color_ff, held_color_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_rgb_ff, rsp_rgb_in;
   logic [31:0] rsp_desc_ff, rsp_desc_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        issue;
   logic        accept;
   logic        last_pix;
   logic [11:0] base_color;
   logic [11:0] dec_rgb;
   logic [31:0] dec_desc;

   hpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_planes[0] = req_plane0_byte;
   assign req_planes[1] = req_plane1_byte;
   assign req_planes[2] = req_plane2_byte;
   assign req_planes[3] = req_plane3_byte;
   assign req_planes[4] = req_plane4_byte;
   assign req_planes[5] = req_plane5_byte;
   assign req_planes[6] = req_plane6_byte;
   assign req_planes[7] = req_plane7_byte;

   assign issue     = item_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign last_pix  = (pix_cnt_ff == 3'(PixelsPerItem - 1));
   assign req_ready = ~item_valid_ff | (issue & last_pix);
   assign accept    = req_valid & req_ready;

   // row start reloads the held color ahead of the first pixel
   assign base_color = (row_start_ff && pix_cnt_ff == '0) ? cfg.palette[0][11:0]
                                                           : held_color_ff;

   hpd_decode u_decode (
      .planes     (planes_ff),
      .pix_idx    (pix_cnt_ff),
      .base_color (base_color),
      .cfg        (cfg),
      .rgb        (dec_rgb),
      .descriptor (dec_desc)
   );

   always_comb begin
      planes_in     = planes_ff;
      row_start_in  = row_start_ff;
      item_valid_in = item_valid_ff;
      pix_cnt_in    = pix_cnt_ff;
      held_color_in = held_color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rgb_in    = rsp_rgb_ff;
      rsp_desc_in   = rsp_desc_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (issue) begin
         rsp_valid_in  = 1'b1;
         rsp_rgb_in    = dec_rgb;
         rsp_desc_in   = dec_desc;
         rsp_last_in   = last_pix;
         held_color_in = dec_rgb;
         pix_cnt_in    = pix_cnt_ff + 3'd1;
         if (last_pix) begin
            item_valid_in = 1'b0;
         end
      end

      if (accept) begin
         item_valid_in = 1'b1;
         pix_cnt_in    = '0;
         row_start_in  = req_row_start;
         // planes at or above the depth read as zero
         for (int p = 0; p < NumPlanes; p++) begin
            planes_in[p] = ({1'b0, 3'(p)} < cfg.plane_depth) ? req_planes[p] : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pix_cnt_ff    <= '0;
         held_color_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pix_cnt_ff    <= pix_cnt_in;
         held_color_ff <= held_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      planes_ff    <= planes_in;
      row_start_ff <= row_start_in;
      rsp_rgb_ff   <= rsp_rgb_in;
      rsp_desc_ff  <= rsp_desc_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_rgb        = rsp_rgb_ff;
   assign rsp_texel_descriptor = rsp_desc_ff;
   assign rsp_last_of_group    = rsp_last_ff;

   `HPD_ASSERT_NOW(a_idle_count_zero, clock, reset, !item_valid_ff, pix_cnt_ff == '0, "pixel count not zero while no request held")
   `HPD_ASSERT_NEXT(a_accept_starts, clock, reset, accept, item_valid_ff && pix_cnt_ff == '0, "accepted request does not start at pixel zero")
   `HPD_ASSERT_NEXT(a_last_marked, clock, reset, issue && last_pix, rsp_valid_ff && rsp_last_ff, "eighth pixel not marked last")
   `HPD_ASSERT_NEXT(a_held_tracks, clock, reset, issue, held_color_ff == rsp_rgb_ff, "held color differs from last issued pixel")

endmodule

`default_nettype wire
